// File: hw/rtl/sksa_pkg.sv
// Shared types, codes and constants for the seed and key security access block.
package sksa_pkg;

  localparam int LEVEL_ENTRIES_DEF = 64;
  localparam int LVL_W = 7;

  // configuration register indexes
  localparam logic [1:0] REG_KEY_MASK   = 2'd0;
  localparam logic [1:0] REG_THRESHOLD  = 2'd1;
  localparam logic [1:0] REG_LOCK_TICKS = 2'd2;
  localparam logic [1:0] REG_FIRST_SEED = 2'd3;

  localparam logic [15:0] KEY_MASK_RST   = 16'd0;
  localparam logic [7:0]  THRESHOLD_RST  = 8'd3;
  localparam logic [31:0] LOCK_TICKS_RST = 32'd10;
  localparam logic [15:0] FIRST_SEED_RST = 16'd1;

  localparam logic [7:0]  KEY_LEN  = 8'd2;
  localparam logic [15:0] SEED_MAX = 16'hFFFF;

  typedef enum logic [1:0] {
    KIND_SEED   = 2'd0,
    KIND_KEY_OK = 2'd1,
    KIND_NEG    = 2'd2,
    KIND_SUPP   = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_UNSUPPORTED = 3'd1,
    ST_LENGTH      = 3'd2,
    ST_SEQUENCE    = 3'd3,
    ST_BAD_KEY     = 3'd4,
    ST_ATTEMPTS    = 3'd5,
    ST_REJECT      = 3'd6
  } status_t;

  // request classification, captured at acceptance
  typedef struct packed {
    logic             is_tick;
    logic             no_sub;
    logic             bad_sub;   // reserved or level beyond the table
    logic             is_seed;
    logic             len_ok;
    logic             suppress;
    logic             canceled;
    logic [LVL_W-1:0] lvl;
    logic [15:0]      key;
    logic [7:0]       sub;
  } decode_t;

endpackage

// File: hw/rtl/sksa_level_mem.sv
// Level table: per-level seed memory with registered read and allocation bits.
module sksa_level_mem import sksa_pkg::*; #(
  parameter int ENTRIES = LEVEL_ENTRIES_DEF,
  localparam int IDX_W = $clog2(ENTRIES)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_idx,
  output logic             rd_alloc,
  output logic [15:0]      rd_seed,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_idx,
  input  logic [15:0]      wr_seed
);

  logic [15:0]        seeds [ENTRIES];
  logic [ENTRIES-1:0] alloc;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      seeds[wr_idx] <= wr_seed;
    end
    if (rd_en) begin
      rd_seed <= seeds[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      alloc    <= '0;
      rd_alloc <= 1'b0;
    end else begin
      if (wr_en) begin
        alloc[wr_idx] <= 1'b1;
      end
      if (rd_en) begin
        rd_alloc <= alloc[rd_idx];
      end
    end
  end

endmodule

// File: hw/rtl/sksa_decode.sv
// Request classifier: sub-function masking, level index and reserved ranges.
module sksa_decode import sksa_pkg::*; #(
  parameter int LEVEL_ENTRIES = LEVEL_ENTRIES_DEF
) (
  input  logic        opcode,
  input  logic        has_subfunction,
  input  logic [7:0]  subfunction,
  input  logic [7:0]  record_length,
  input  logic [15:0] key_value,
  input  logic        canceled,
  output decode_t     dec
);

  logic [6:0] neutral;
  logic [6:0] neutral_m1;
  logic [6:0] lvl;
  logic       reserved;
  logic       beyond;

  always_comb begin
    neutral    = subfunction[6:0];
    neutral_m1 = neutral - 7'd1;
    // seed requests are odd, key requests the even one above
    lvl        = neutral[0] ? (neutral >> 1) : (neutral_m1 >> 1);
    reserved   = neutral inside {7'h00, [7'h43:7'h7E]};
    beyond     = {1'b0, lvl} >= 8'(LEVEL_ENTRIES);

    dec.is_tick  = opcode;
    dec.no_sub   = !has_subfunction;
    dec.bad_sub  = reserved || beyond;
    dec.is_seed  = neutral[0];
    dec.len_ok   = record_length == KEY_LEN;
    dec.suppress = subfunction[7];
    dec.canceled = canceled;
    dec.lvl      = lvl;
    dec.key      = key_value;
    dec.sub      = subfunction;
  end

endmodule

// File: hw/rtl/seed_key_security_access.sv
// Seed and key security access unlock, server side.
// Results: the result register loads from the execute state, entered from the idle state
// that accepts a beat (held there while the output side stalls); ticks give no result.
// A new beat is taken only in the idle state, so each item finishes before the next.
// Reset (rst, synchronous): control state and configuration to reset values,
// allocation bits cleared at once; no clearing pass.
module seed_key_security_access import sksa_pkg::*; #(
  parameter int LEVEL_ENTRIES = LEVEL_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        opcode,
  input  logic        has_subfunction,
  input  logic [7:0]  subfunction,
  input  logic [7:0]  record_length,
  input  logic [15:0] key_value,
  input  logic        canceled,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  response_kind,
  output logic [2:0]  status,
  output logic [15:0] seed_value,
  output logic [7:0]  echoed_subfunction,
  output logic        lockout_active
);

  localparam int IDX_W = $clog2(LEVEL_ENTRIES);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state, state_next;

  logic [15:0] key_mask;
  logic [7:0]  attempt_threshold;
  logic [31:0] lockout_ticks;
  logic [15:0] first_seed;

  logic [15:0]      seed_ctr, seed_ctr_next;
  logic [LVL_W-1:0] unlocked_level, unlocked_level_next;
  logic             any_unlocked, any_unlocked_next;
  logic [8:0]       failed_count, failed_count_next;
  logic [31:0]      lockout_remaining, lockout_remaining_next;

  decode_t dec, dec_q;

  logic        accept;
  logic        mem_alloc;
  logic [15:0] mem_seed;
  logic        mem_wr;

  logic        res_load;
  kind_t       res_kind;
  status_t     res_status;
  logic [15:0] res_seed;
  logic [7:0]  res_echo;
  logic        out_free;
  logic        key_match;
  logic [8:0]  cnt_inc;
  logic [15:0] seed_cur;

  sksa_decode #(.LEVEL_ENTRIES(LEVEL_ENTRIES)) u_decode (
    .opcode          (opcode),
    .has_subfunction (has_subfunction),
    .subfunction     (subfunction),
    .record_length   (record_length),
    .key_value       (key_value),
    .canceled        (canceled),
    .dec             (dec)
  );

  sksa_level_mem #(.ENTRIES(LEVEL_ENTRIES)) u_level_mem (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (accept),
    .rd_idx   (dec.lvl[IDX_W-1:0]),
    .rd_alloc (mem_alloc),
    .rd_seed  (mem_seed),
    .wr_en    (mem_wr),
    .wr_idx   (dec_q.lvl[IDX_W-1:0]),
    .wr_seed  (seed_ctr)
  );

  assign in_ready = state == S_IDLE;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_mask          <= KEY_MASK_RST;
      attempt_threshold <= THRESHOLD_RST;
      lockout_ticks     <= LOCK_TICKS_RST;
      first_seed        <= FIRST_SEED_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_KEY_MASK:   key_mask          <= cfg_data[15:0];
        REG_THRESHOLD:  attempt_threshold <= cfg_data[7:0];
        REG_LOCK_TICKS: lockout_ticks     <= cfg_data;
        REG_FIRST_SEED: first_seed        <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      dec_q <= dec;
    end
  end

  always_comb begin
    state_next             = state;
    seed_ctr_next          = seed_ctr;
    unlocked_level_next    = unlocked_level;
    any_unlocked_next      = any_unlocked;
    failed_count_next      = failed_count;
    lockout_remaining_next = lockout_remaining;
    mem_wr     = 1'b0;
    res_load   = 1'b0;
    res_kind   = KIND_NEG;
    res_status = ST_OK;
    res_seed   = '0;
    res_echo   = dec_q.sub;
    out_free   = !out_valid || out_ready;
    key_match  = (mem_seed ^ key_mask) == dec_q.key;
    cnt_inc    = failed_count + 9'd1;
    seed_cur   = mem_alloc ? mem_seed : seed_ctr;

    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (dec_q.is_tick) begin
          if (lockout_remaining != '0) begin
            lockout_remaining_next = lockout_remaining - 32'd1;
          end
          state_next = S_IDLE;
        end else if (out_free) begin
          res_load   = 1'b1;
          state_next = S_IDLE;
          if (dec_q.no_sub) begin
            res_status = dec_q.canceled ? ST_REJECT : ST_LENGTH;
            res_echo   = '0;
          end else if (dec_q.bad_sub) begin
            res_status = dec_q.canceled ? ST_REJECT : ST_UNSUPPORTED;
          end else if (lockout_remaining != '0) begin
            res_status = dec_q.canceled ? ST_REJECT : ST_ATTEMPTS;
          end else if (dec_q.is_seed) begin
            if (!mem_alloc) begin
              mem_wr        = 1'b1;
              seed_ctr_next = (seed_ctr == SEED_MAX) ? first_seed : seed_ctr + 16'd1;
            end
            if (dec_q.suppress) begin
              res_kind = KIND_SUPP;
            end else begin
              res_kind = KIND_SEED;
              res_seed = (any_unlocked && unlocked_level == dec_q.lvl) ? '0 : seed_cur;
            end
          end else if (!dec_q.len_ok) begin
            res_status = ST_LENGTH;
          end else if (!mem_alloc) begin
            res_status = ST_SEQUENCE;
          end else if (key_match) begin
            unlocked_level_next = dec_q.lvl;
            any_unlocked_next   = 1'b1;
            res_kind            = dec_q.suppress ? KIND_SUPP : KIND_KEY_OK;
          end else begin
            if (cnt_inc > {1'b0, attempt_threshold}) begin
              lockout_remaining_next = lockout_ticks;
              failed_count_next      = '0;
            end else begin
              failed_count_next = cnt_inc;
            end
            res_status = (lockout_remaining_next != '0) ? ST_ATTEMPTS : ST_BAD_KEY;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      seed_ctr          <= FIRST_SEED_RST;
      unlocked_level    <= '0;
      any_unlocked      <= 1'b0;
      failed_count      <= '0;
      lockout_remaining <= '0;
      out_valid         <= 1'b0;
    end else begin
      state             <= state_next;
      seed_ctr          <= seed_ctr_next;
      unlocked_level    <= unlocked_level_next;
      any_unlocked      <= any_unlocked_next;
      failed_count      <= failed_count_next;
      lockout_remaining <= lockout_remaining_next;
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      response_kind      <= res_kind;
      status             <= res_status;
      seed_value         <= res_seed;
      echoed_subfunction <= res_echo;
      lockout_active     <= lockout_remaining_next != '0;
    end
  end

  // a result beat only ever appears out of the execute step
  a_result_from_exec: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_EXEC))
    else $error("result beat without an execute step");

  // a stalled output keeps a pending request in the execute step
  a_exec_holds: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC && !dec_q.is_tick && out_valid && !out_ready) |=> state == S_EXEC)
    else $error("request finished while the result register was occupied");

  // once a level is unlocked, some level stays unlocked
  a_unlock_sticky: assert property (@(posedge clk) disable iff (rst)
    !$fell(any_unlocked))
    else $error("unlock withdrawn");

  // table writes happen only for seed requests in the execute step
  a_write_on_seed: assert property (@(posedge clk) disable iff (rst)
    mem_wr |-> (state == S_EXEC && dec_q.is_seed && res_load))
    else $error("table written outside a seed allocation");

endmodule
